FILE: rtl/ddo_pkg.sv
`default_nettype none
package ddo_pkg;
    localparam int TableLen = 30;
    localparam logic signed [63:0] GainQ30 = 64'sd652032875;
    localparam logic [31:0] RadToTurnQ16 = 32'd683565276;
    localparam logic [63:0] SpeedLimitIn = 64'd17592186044416;
    localparam logic [19:0] UsPerSec = 20'd1000000;

    localparam logic [2:0] CfgTickToDist = 3'd0;
    localparam logic [2:0] CfgTickToAngle = 3'd1;
    localparam logic [2:0] CfgStartX = 3'd2;
    localparam logic [2:0] CfgStartY = 3'd3;
    localparam logic [2:0] CfgStartHead = 3'd4;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
                5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
                5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
                5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
                5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        begin
            if (v > 66'sh7FFFFFFF) r = 32'sh7FFFFFFF;
            else if (v < -66'sh80000000) r = -32'sh80000000;
            else r = v[31:0];
            return r;
        end
    endfunction

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_MUL1  = 11'b00000000010,
        S_MUL2  = 11'b00000000100,
        S_PH    = 11'b00000001000,
        S_CORD  = 11'b00000010000,
        S_MX    = 11'b00000100000,
        S_MY    = 11'b00001000000,
        S_DIVST = 11'b00010000000,
        S_DIV   = 11'b00100000000,
        S_DIVEN = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [23:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;
endpackage
`default_nettype wire

FILE: rtl/ddo_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle, 64 quotient bits
module ddo_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ddo_pkg::t_div_req i_req,
    output ddo_pkg::t_div_rsp      o_rsp
);
    logic [63:0] r_q, n_q;
    logic [24:0] r_rem, n_rem;
    logic [23:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [24:0] w_sh;

    always_comb begin
        w_sh  = {r_rem[23:0], r_q[63]};
        n_q   = {r_q[62:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem = w_sh - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_q <= i_req.num; r_rem <= '0; r_den <= i_req.den;
                r_cnt <= 7'd64; r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q <= n_q; r_rem <= n_rem;
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_rsp = {r_done, r_q};
endmodule
`default_nettype wire

FILE: rtl/differential_drive_odometry.sv
`default_nettype none
// An accepted sample runs through four 64-bit divisions on one shared restoring
// divider, which dominate its latency; a speed that saturates skips its division.
// A reset item (s_axis_tuser set) reloads the start pose and clears the speeds.
// Throughput: one item at a time, the next beat is taken the cycle after the
// result is registered. Reset (i_rst_n low, synchronous) clears state, handshakes,
// config and pose registers; sample and output data registers are not cleared.
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [31:0] tick_sum, [63:32] tick_diff, [87:64] elapsed_us
    input  wire logic [87:0]  s_axis_tdata,
    // [0] mode
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // x_pos, y_pos, heading, lin_speed, x_speed, y_speed, turn_speed, 32b each
    output logic [223:0]      m_axis_tdata,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);
    localparam int NSteps = (CORDIC_STEPS < ddo_pkg::TableLen) ? CORDIC_STEPS
                                                                : ddo_pkg::TableLen;
    localparam int IW = $clog2(NSteps + 1);

    ddo_pkg::t_state r_st;
    logic [31:0] r_k_dist, r_k_ang;
    logic signed [31:0] r_sx, r_sy, r_sh;
    logic signed [31:0] r_px, r_py, r_hoff, r_lhead;
    logic [31:0] r_lts;
    logic signed [31:0] r_lin, r_vx, r_vy, r_vt, r_head;
    logic [31:0] r_ts, r_td;
    logic [23:0] r_us;
    logic signed [63:0] r_step, r_dx, r_dy, r_x, r_y, r_z, r_c, r_s;
    logic r_flip;
    logic [IW-1:0] r_i;
    logic [1:0] r_k;
    logic r_neg;
    logic r_half;
    logic [63:0] r_acc;
    logic [223:0] r_out;

    ddo_pkg::t_div_req w_req;
    ddo_pkg::t_div_rsp w_rsp;
    ddo_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // operand magnitudes
    logic [31:0] w_delta;
    logic [63:0] w_smag;
    logic [31:0] w_cmag, w_sinmag;
    assign w_delta  = r_ts - r_lts;
    assign w_smag   = r_step[63] ? 64'(-r_step) : 64'(r_step);
    assign w_cmag   = r_c[63] ? 32'(-r_c) : r_c[31:0];
    assign w_sinmag = r_s[63] ? 32'(-r_s) : r_s[31:0];

    // shared 32x32 magnitude multiplier; the step product takes two passes
    logic [31:0] w_ma, w_mb;
    logic        w_mneg;
    logic [63:0] w_prod, w_r16m, w_q30lo, w_dsum;
    logic signed [63:0] w_r16, w_dq;
    always_comb begin
        w_ma = '0; w_mb = '0; w_mneg = 1'b0;
        case (r_st)
            ddo_pkg::S_MUL1: begin
                w_ma = w_delta[31] ? -w_delta : w_delta;
                w_mb = r_k_dist;
                w_mneg = w_delta[31];
            end
            ddo_pkg::S_MUL2: begin
                w_ma = r_td[31] ? -r_td : r_td;
                w_mb = r_k_ang;
                w_mneg = r_td[31];
            end
            ddo_pkg::S_PH: begin
                w_ma = r_head[31] ? -r_head : r_head;
                w_mb = ddo_pkg::RadToTurnQ16;
                w_mneg = r_head[31];
            end
            ddo_pkg::S_MX: begin
                w_ma = r_half ? w_smag[63:32] : w_smag[31:0];
                w_mb = w_cmag;
                w_mneg = r_step[63] ^ r_c[63];
            end
            ddo_pkg::S_MY: begin
                w_ma = r_half ? w_smag[63:32] : w_smag[31:0];
                w_mb = w_sinmag;
                w_mneg = r_step[63] ^ r_s[63];
            end
            default: ;
        endcase
        w_prod = 64'(w_ma) * 64'(w_mb);
        w_r16m = (w_prod + 64'h8000) >> 16;
        w_r16 = w_mneg ? -$signed(w_r16m) : $signed(w_r16m);
        // low half rounded at bit 30; high half lands exactly 2 bits up
        w_q30lo = (w_prod + 64'h2000_0000) >> 30;
        w_dsum = r_acc + (w_prod << 2);
        w_dq = w_mneg ? -$signed(w_dsum) : $signed(w_dsum);
    end

    logic signed [63:0] w_xs, w_ys;
    logic [31:0] w_ph;
    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    assign w_ph = w_r16[31:0];

    // rate operand for speed k
    logic signed [63:0] w_rn;
    logic [63:0] w_rm;
    always_comb begin
        case (r_k)
            2'd0: w_rn = r_step;
            2'd1: w_rn = r_dx;
            2'd2: w_rn = r_dy;
            default: w_rn = 64'(r_head) - 64'(r_lhead);
        endcase
        w_rm = w_rn[63] ? 64'(-w_rn) : 64'(w_rn);
    end

    logic [63:0] w_q;
    logic signed [31:0] w_sp;
    always_comb begin
        w_q = w_rsp.quo;
        if (r_neg && w_q > 64'h80000000) w_q = 64'h80000000;
        if (!r_neg && w_q > 64'h7FFFFFFF) w_q = 64'h7FFFFFFF;
        w_sp = r_neg ? -$signed(w_q[31:0]) : $signed(w_q[31:0]);
    end

    logic w_sat;
    assign w_sat = w_rm > ddo_pkg::SpeedLimitIn;

    always_comb begin
        w_req.start = (r_st == ddo_pkg::S_DIVST) && !w_sat;
        w_req.num = w_rm * 64'(ddo_pkg::UsPerSec) + 64'(r_us >> 1);
        w_req.den = r_us;
    end

    logic w_out_free;
    assign w_out_free = !m_axis_tvalid || m_axis_tready;

    assign s_axis_tready = (r_st == ddo_pkg::S_IDLE);
    assign o_cfg_ready = (r_st == ddo_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ddo_pkg::S_IDLE;
            m_axis_tvalid <= 1'b0;
            r_half <= 1'b0;
            r_k_dist <= '0; r_k_ang <= '0; r_sx <= '0; r_sy <= '0; r_sh <= '0;
            r_px <= '0; r_py <= '0; r_hoff <= '0; r_lhead <= '0; r_lts <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ddo_pkg::CfgTickToDist:  r_k_dist <= i_cfg_data;
                    ddo_pkg::CfgTickToAngle: r_k_ang <= i_cfg_data;
                    ddo_pkg::CfgStartX:      r_sx <= i_cfg_data;
                    ddo_pkg::CfgStartY:      r_sy <= i_cfg_data;
                    ddo_pkg::CfgStartHead:   r_sh <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_st == ddo_pkg::S_OUT && w_out_free) m_axis_tvalid <= 1'b1;
            else if (m_axis_tready) m_axis_tvalid <= 1'b0;
            case (r_st)
                ddo_pkg::S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_ts <= s_axis_tdata[31:0];
                    r_td <= s_axis_tdata[63:32];
                    r_us <= (s_axis_tdata[87:64] == 24'd0) ? 24'd1 : s_axis_tdata[87:64];
                    if (s_axis_tuser) begin
                        r_px <= r_sx; r_py <= r_sy; r_hoff <= r_sh; r_lts <= '0;
                        r_lin <= '0; r_vx <= '0; r_vy <= '0; r_vt <= '0;
                        r_st <= ddo_pkg::S_OUT;
                    end else r_st <= ddo_pkg::S_MUL1;
                end
                ddo_pkg::S_MUL1: begin
                    r_step <= w_r16;
                    r_st <= ddo_pkg::S_MUL2;
                end
                ddo_pkg::S_MUL2: begin
                    r_head <= ddo_pkg::sat32(66'(w_r16) + 66'(r_hoff));
                    r_st <= ddo_pkg::S_PH;
                end
                ddo_pkg::S_PH: begin
                    r_flip <= w_ph[31] ^ w_ph[30];
                    r_z <= {{32{w_ph[31] ^ (w_ph[31] ^ w_ph[30])}},
                            w_ph[31] ^ (w_ph[31] ^ w_ph[30]), w_ph[30:0]};
                    r_x <= ddo_pkg::GainQ30; r_y <= '0; r_i <= '0;
                    r_st <= ddo_pkg::S_CORD;
                end
                ddo_pkg::S_CORD: begin
                    if (r_i == IW'(NSteps)) begin
                        r_c <= r_flip ? -r_x : r_x;
                        r_s <= r_flip ? -r_y : r_y;
                        r_st <= ddo_pkg::S_MX;
                    end else begin
                        if (!r_z[63]) begin
                            r_x <= r_x - w_ys; r_y <= r_y + w_xs;
                            r_z <= r_z - 64'(ddo_pkg::atan_turn(5'(r_i)));
                        end else begin
                            r_x <= r_x + w_ys; r_y <= r_y - w_xs;
                            r_z <= r_z + 64'(ddo_pkg::atan_turn(5'(r_i)));
                        end
                        r_i <= r_i + IW'(1);
                    end
                end
                ddo_pkg::S_MX: begin
                    if (!r_half) begin
                        r_acc <= w_q30lo;
                        r_half <= 1'b1;
                    end else begin
                        r_dx <= w_dq;
                        r_px <= ddo_pkg::sat32(66'(r_px) + 66'(w_dq));
                        r_half <= 1'b0;
                        r_st <= ddo_pkg::S_MY;
                    end
                end
                ddo_pkg::S_MY: begin
                    if (!r_half) begin
                        r_acc <= w_q30lo;
                        r_half <= 1'b1;
                    end else begin
                        r_dy <= w_dq;
                        r_py <= ddo_pkg::sat32(66'(r_py) + 66'(w_dq));
                        r_half <= 1'b0;
                        r_lts <= r_ts;
                        r_k <= 2'd0;
                        r_st <= ddo_pkg::S_DIVST;
                    end
                end
                ddo_pkg::S_DIVST: begin
                    r_neg <= w_rn[63];
                    r_st <= w_sat ? ddo_pkg::S_DIVEN : ddo_pkg::S_DIV;
                end
                ddo_pkg::S_DIV: if (w_rsp.done) r_st <= ddo_pkg::S_DIVEN;
                ddo_pkg::S_DIVEN: begin
                    logic signed [31:0] v;
                    v = w_sp;
                    if (w_sat) v = r_neg ? -32'sh80000000 : 32'sh7FFFFFFF;
                    case (r_k)
                        2'd0: r_lin <= v;
                        2'd1: r_vx <= v;
                        2'd2: r_vy <= v;
                        default: r_vt <= v;
                    endcase
                    if (r_k == 2'd3) begin
                        r_lhead <= r_head;
                        r_st <= ddo_pkg::S_OUT;
                    end else begin
                        r_k <= r_k + 2'd1;
                        r_st <= ddo_pkg::S_DIVST;
                    end
                end
                ddo_pkg::S_OUT: begin
                    // wait here while the previous beat is still held
                    if (w_out_free) begin
                        r_out <= {r_vt, r_vy, r_vx, r_lin, r_lhead, r_py, r_px};
                        r_st <= ddo_pkg::S_IDLE;
                    end
                end
                default: r_st <= ddo_pkg::S_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = r_out;
endmodule
`default_nettype wire
